>>> rtl/core/sph_artificial_viscosity_macros.svh
// Assertion macros for the artificial viscosity block.
// Depends on nothing; the user provides clk and rst_n in scope.
`ifndef SPH_ARTIFICIAL_VISCOSITY_MACROS_SVH
`define SPH_ARTIFICIAL_VISCOSITY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SAV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SAV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAV_ASSERT(lbl, prop, msg)
`define SAV_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/core/sav_pkg.sv
// Shared types, codes and constants of the artificial viscosity block.
// No dependencies.
package sav_pkg;

  localparam logic [30:0] CAP31     = 31'h7FFF_FFFF;
  localparam logic [12:0] TENTH_Q16 = 13'd6554;
  localparam int          NUM_W     = 95;
  localparam int          DEN_W     = 64;
  localparam int          QUO_W     = 31;

  localparam logic KIND_PAIR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    REG_SHEAR  = 3'd0,
    REG_BULK   = 3'd1,
    REG_SOUND  = 3'd2,
    REG_SMOOTH = 3'd3,
    REG_MASS   = 3'd4,
    REG_TRACK  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] rel_vel_x;
    logic signed [31:0] rel_vel_y;
    logic signed [31:0] rel_pos_x;
    logic signed [31:0] rel_pos_y;
    logic        [30:0] density_self;
    logic        [30:0] density_other;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic        [30:0] prior_mu;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic        [30:0] max_mu;
  } out_item_t;

  typedef enum logic [4:0] {
    STEP_NONE, STEP_P1, STEP_P2, STEP_VR, STEP_RX, STEP_RY, STEP_EH, STEP_EE,
    STEP_N0, STEP_N1, STEP_MU, STEP_T0, STEP_T1, STEP_Q0, STEP_Q1, STEP_PIV,
    STEP_G0, STEP_G1, STEP_G2, STEP_GU
  } step_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_P1, ST_P2, ST_VR, ST_RX, ST_RY, ST_EH, ST_EE, ST_N0, ST_N1,
    ST_MU_GO, ST_MU_WAIT, ST_T0, ST_T1, ST_Q0, ST_Q1, ST_PIV_GO, ST_PIV_WAIT,
    ST_GX0, ST_GX1, ST_GX2, ST_GXU, ST_GY0, ST_GY1, ST_GY2, ST_GYU
  } state_t;

  typedef struct packed {
    step_t step;
    logic  axis_y;
    logic  div_start;
    logic  item_load;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic approach;
    logic div_done;
  } status_t;

endpackage

>>> rtl/core/sph_artificial_viscosity.sv
// Channel  Handshake           Payload
// in_      in_valid/in_ready   sav_pkg::in_item_t (pair or end-of-list)
// out_     out_valid/out_ready sav_pkg::out_item_t (one per end beat)
// cfg_     cfg_we              cfg_index, cfg_data (no read-back)
//
// A pair moving apart ends after the P1, P2 and VR steps; an approaching
// pair also runs two passes of the bit-serial divider and the shared
// 32x32 multiplier steps.
// Synchronous active-low reset clears sums and max |mu| and sets the config registers to defaults.
// A waiting result blocks only the next end beat, not pair beats.
`include "sph_artificial_viscosity_macros.svh"
module sph_artificial_viscosity (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sav_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sav_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [30:0]         cfg_data
);

  sav_pkg::cmd_t    cmd;
  sav_pkg::status_t status;

  sav_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sav_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  `SAV_ASSERT(a_end_gives_beat, (in_valid && in_ready && in_data.kind == sav_pkg::KIND_END) |=> out_valid, "end beat did not raise out_valid")
  `SAV_ASSERT(a_pair_no_beat, (in_valid && in_ready && in_data.kind == sav_pkg::KIND_PAIR) |=> !$rose(out_valid), "pair beat produced a result")
  `SAV_ASSERT(a_div_done_owned, status.div_done |-> (cmd.step == sav_pkg::STEP_MU || cmd.step == sav_pkg::STEP_PIV), "divider finished outside a divide step")
  `SAV_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "out_valid high after reset")

endmodule

>>> rtl/core/sav_div.sv
// Restoring divider, one quotient bit per cycle, saturating to 31 bits.
// Depends on sav_pkg for widths.
module sav_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sav_pkg::NUM_W-1:0]    num,
  input  logic [sav_pkg::DEN_W-1:0]    den,
  output logic                         done,
  output logic [sav_pkg::QUO_W-1:0]    quo
);

  logic                      busy_r;
  logic [4:0]                cnt_r;
  logic                      done_r;
  logic [sav_pkg::NUM_W-1:0] rem_r;
  logic [sav_pkg::NUM_W-1:0] dsh_r;
  logic [sav_pkg::QUO_W-1:0] quo_r;
  logic                      ge;
  logic [sav_pkg::NUM_W-1:0] diff;

  assign ge   = rem_r >= dsh_r;
  assign diff = rem_r - dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          // quotient would not fit: saturate at once
          if (ge) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            cnt_r <= 5'd1;
          end
        end else if (cnt_r == 5'(sav_pkg::QUO_W)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {den, {sav_pkg::QUO_W{1'b0}}};
      quo_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        if (ge) quo_r <= '1;
        else    dsh_r <= dsh_r >> 1;
      end else begin
        if (ge) rem_r <= diff;
        quo_r <= {quo_r[sav_pkg::QUO_W-2:0], ge};
        dsh_r <= dsh_r >> 1;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> rtl/core/sav_dp.sv
// Datapath: config registers, shared 32x32 multiplier, accumulators, divider.
// Depends on sav_pkg and sav_div.
module sav_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [30:0]         cfg_data,
  input  sav_pkg::in_item_t   in_data,
  input  sav_pkg::cmd_t       cmd,
  output sav_pkg::status_t    status,
  output sav_pkg::out_item_t  out_data
);

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  logic [30:0] shear_r, bulk_r, sound_r, smooth_r, mass_r;
  logic        track_r;

  sav_pkg::in_item_t  item_r;
  sav_pkg::out_item_t out_r;

  logic signed [31:0] sum_x_r, sum_y_r;
  logic        [30:0] largest_r;

  logic [63:0] p1_r, p2_r, absvr_r, den_r;
  logic [28:0] eh_r;
  logic [95:0] acc_r;
  logic [62:0] tq_r;
  logic [30:0] mu_r, piv_r;
  logic [61:0] g_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [64:0] vr_sum, vr_neg;
  logic [44:0] eh_tmp;
  logic [31:0] rho_sum;
  logic        div_done;
  logic [30:0] div_q;
  logic [94:0] div_num;
  logic [63:0] div_den;
  logic [30:0] mu_val;
  logic [31:0] grad_sel;
  logic [60:0] term_val;
  logic signed [31:0] term;
  logic signed [31:0] sum_sel;
  logic [32:0] sum_ext;
  logic signed [31:0] sum_sat;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shear_r  <= 31'd65536;
      bulk_r   <= 31'd131072;
      sound_r  <= 31'd655360;
      smooth_r <= 31'd65536;
      mass_r   <= 31'd65536;
      track_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sav_pkg::REG_SHEAR:  shear_r  <= cfg_data;
        sav_pkg::REG_BULK:   bulk_r   <= cfg_data;
        sav_pkg::REG_SOUND:  sound_r  <= cfg_data;
        sav_pkg::REG_SMOOTH: smooth_r <= cfg_data;
        sav_pkg::REG_MASS:   mass_r   <= cfg_data;
        sav_pkg::REG_TRACK:  track_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign grad_sel = cmd.axis_y ? item_r.grad_y : item_r.grad_x;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step)
      sav_pkg::STEP_P1: begin
        mul_a = mag32(item_r.rel_vel_x);
        mul_b = mag32(item_r.rel_pos_x);
      end
      sav_pkg::STEP_P2: begin
        mul_a = mag32(item_r.rel_vel_y);
        mul_b = mag32(item_r.rel_pos_y);
      end
      sav_pkg::STEP_RX: begin
        mul_a = mag32(item_r.rel_pos_x);
        mul_b = mag32(item_r.rel_pos_x);
      end
      sav_pkg::STEP_RY: begin
        mul_a = mag32(item_r.rel_pos_y);
        mul_b = mag32(item_r.rel_pos_y);
      end
      sav_pkg::STEP_EH: begin
        mul_a = {1'b0, smooth_r};
        mul_b = {19'd0, sav_pkg::TENTH_Q16};
      end
      sav_pkg::STEP_EE: begin
        mul_a = {3'd0, eh_r};
        mul_b = {3'd0, eh_r};
      end
      sav_pkg::STEP_N0: begin
        mul_a = {1'b0, smooth_r};
        mul_b = absvr_r[31:0];
      end
      sav_pkg::STEP_N1: begin
        mul_a = {1'b0, smooth_r};
        mul_b = absvr_r[63:32];
      end
      sav_pkg::STEP_T0: begin
        mul_a = {1'b0, bulk_r};
        mul_b = {1'b0, mu_r};
      end
      sav_pkg::STEP_T1: begin
        mul_a = {1'b0, shear_r};
        mul_b = {1'b0, sound_r};
      end
      sav_pkg::STEP_Q0: begin
        mul_a = tq_r[31:0];
        mul_b = {1'b0, mu_r};
      end
      sav_pkg::STEP_Q1: begin
        mul_a = {1'b0, tq_r[62:32]};
        mul_b = {1'b0, mu_r};
      end
      sav_pkg::STEP_G0: begin
        mul_a = mag32(grad_sel);
        mul_b = {1'b0, piv_r};
      end
      sav_pkg::STEP_G1: begin
        mul_a = g_r[31:0];
        mul_b = {1'b0, mass_r};
      end
      sav_pkg::STEP_G2: begin
        mul_a = {2'd0, g_r[61:32]};
        mul_b = {1'b0, mass_r};
      end
      default: ;
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign vr_sum = {p1_r[63], p1_r} + {p2_r[63], p2_r};
  assign vr_neg = 65'd0 - vr_sum;
  assign eh_tmp = prod[44:0] + 45'd32768;
  assign rho_sum = {1'b0, item_r.density_self} + {1'b0, item_r.density_other};

  assign div_num = (cmd.step == sav_pkg::STEP_PIV) ? {acc_r[93:0], 1'b0} : acc_r[94:0];
  assign div_den = (cmd.step == sav_pkg::STEP_PIV) ? {16'd0, rho_sum, 16'd0} : den_r;

  sav_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign mu_val = (den_r == '0) ? '0 : div_q;

  // per-axis term: magnitude truncated, then saturated with the gradient sign
  assign term_val = acc_r[92:32];
  always_comb begin
    if (grad_sel[31]) begin
      term = (|term_val[60:31]) ? 32'sh8000_0000 : -$signed(term_val[31:0]);
    end else begin
      term = (|term_val[60:31]) ? 32'sh7FFF_FFFF : $signed(term_val[31:0]);
    end
  end

  assign sum_sel = cmd.axis_y ? sum_y_r : sum_x_r;
  assign sum_ext = {sum_sel[31], sum_sel} + {term[31], term};
  always_comb begin
    if (sum_ext[32] != sum_ext[31]) begin
      sum_sat = sum_ext[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = $signed(sum_ext[31:0]);
    end
  end

  // accumulators that persist across pairs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      largest_r <= '0;
    end else if (cmd.out_load) begin
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      largest_r <= '0;
    end else begin
      if (cmd.step == sav_pkg::STEP_GU) begin
        if (cmd.axis_y) sum_y_r <= sum_sat;
        else            sum_x_r <= sum_sat;
      end
      if (cmd.step == sav_pkg::STEP_MU && div_done && track_r && mu_val > largest_r) begin
        largest_r <= mu_val;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) item_r <= in_data;
    if (cmd.out_load) begin
      out_r.accel_x <= sum_x_r;
      out_r.accel_y <= sum_y_r;
      out_r.max_mu  <= (in_data.prior_mu > largest_r) ? in_data.prior_mu : largest_r;
    end
    unique case (cmd.step)
      sav_pkg::STEP_P1: p1_r <= (item_r.rel_vel_x[31] ^ item_r.rel_pos_x[31]) ? -prod : prod;
      sav_pkg::STEP_P2: p2_r <= (item_r.rel_vel_y[31] ^ item_r.rel_pos_y[31]) ? -prod : prod;
      sav_pkg::STEP_VR: absvr_r <= vr_neg[63:0];
      sav_pkg::STEP_RX, sav_pkg::STEP_N0, sav_pkg::STEP_T0, sav_pkg::STEP_Q0,
      sav_pkg::STEP_G1: acc_r <= {32'd0, prod};
      sav_pkg::STEP_RY: acc_r <= acc_r + {32'd0, prod};
      sav_pkg::STEP_N1, sav_pkg::STEP_Q1, sav_pkg::STEP_G2: acc_r <= acc_r + {prod, 32'd0};
      sav_pkg::STEP_EH: eh_r <= eh_tmp[44:16];
      sav_pkg::STEP_EE: den_r <= acc_r[63:0] + prod;
      sav_pkg::STEP_T1: tq_r <= acc_r[62:0] + prod[62:0];
      sav_pkg::STEP_MU: if (div_done) mu_r <= mu_val;
      sav_pkg::STEP_PIV: if (div_done) piv_r <= div_q;
      sav_pkg::STEP_G0: g_r <= prod[61:0];
      default: ;
    endcase
  end

  assign status.approach = vr_sum[64];
  assign status.div_done = div_done;
  assign out_data        = out_r;

endmodule

>>> rtl/core/sav_ctrl.sv
// Sequencer for one neighbour pair; owns the handshakes.
// Depends on sav_pkg.
module sav_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sav_pkg::status_t  status,
  output sav_pkg::cmd_t     cmd
);

  sav_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  // an end beat needs the output register free; a pair beat does not
  assign in_ready = (state_r == sav_pkg::ST_IDLE) &&
                    (in_kind == sav_pkg::KIND_PAIR || !out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sav_pkg::ST_IDLE:
        if (accept && in_kind == sav_pkg::KIND_PAIR) state_nxt = sav_pkg::ST_P1;
      sav_pkg::ST_P1:       state_nxt = sav_pkg::ST_P2;
      sav_pkg::ST_P2:       state_nxt = sav_pkg::ST_VR;
      // drop pairs that move apart
      sav_pkg::ST_VR:       state_nxt = status.approach ? sav_pkg::ST_RX : sav_pkg::ST_IDLE;
      sav_pkg::ST_RX:       state_nxt = sav_pkg::ST_RY;
      sav_pkg::ST_RY:       state_nxt = sav_pkg::ST_EH;
      sav_pkg::ST_EH:       state_nxt = sav_pkg::ST_EE;
      sav_pkg::ST_EE:       state_nxt = sav_pkg::ST_N0;
      sav_pkg::ST_N0:       state_nxt = sav_pkg::ST_N1;
      sav_pkg::ST_N1:       state_nxt = sav_pkg::ST_MU_GO;
      sav_pkg::ST_MU_GO:    state_nxt = sav_pkg::ST_MU_WAIT;
      sav_pkg::ST_MU_WAIT:  if (status.div_done) state_nxt = sav_pkg::ST_T0;
      sav_pkg::ST_T0:       state_nxt = sav_pkg::ST_T1;
      sav_pkg::ST_T1:       state_nxt = sav_pkg::ST_Q0;
      sav_pkg::ST_Q0:       state_nxt = sav_pkg::ST_Q1;
      sav_pkg::ST_Q1:       state_nxt = sav_pkg::ST_PIV_GO;
      sav_pkg::ST_PIV_GO:   state_nxt = sav_pkg::ST_PIV_WAIT;
      sav_pkg::ST_PIV_WAIT: if (status.div_done) state_nxt = sav_pkg::ST_GX0;
      sav_pkg::ST_GX0:      state_nxt = sav_pkg::ST_GX1;
      sav_pkg::ST_GX1:      state_nxt = sav_pkg::ST_GX2;
      sav_pkg::ST_GX2:      state_nxt = sav_pkg::ST_GXU;
      sav_pkg::ST_GXU:      state_nxt = sav_pkg::ST_GY0;
      sav_pkg::ST_GY0:      state_nxt = sav_pkg::ST_GY1;
      sav_pkg::ST_GY1:      state_nxt = sav_pkg::ST_GY2;
      sav_pkg::ST_GY2:      state_nxt = sav_pkg::ST_GYU;
      sav_pkg::ST_GYU:      state_nxt = sav_pkg::ST_IDLE;
      default:              state_nxt = sav_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.step      = sav_pkg::STEP_NONE;
    cmd.item_load = accept;
    cmd.out_load  = accept && in_kind == sav_pkg::KIND_END;
    unique case (state_r)
      sav_pkg::ST_P1:       cmd.step = sav_pkg::STEP_P1;
      sav_pkg::ST_P2:       cmd.step = sav_pkg::STEP_P2;
      sav_pkg::ST_VR:       cmd.step = sav_pkg::STEP_VR;
      sav_pkg::ST_RX:       cmd.step = sav_pkg::STEP_RX;
      sav_pkg::ST_RY:       cmd.step = sav_pkg::STEP_RY;
      sav_pkg::ST_EH:       cmd.step = sav_pkg::STEP_EH;
      sav_pkg::ST_EE:       cmd.step = sav_pkg::STEP_EE;
      sav_pkg::ST_N0:       cmd.step = sav_pkg::STEP_N0;
      sav_pkg::ST_N1:       cmd.step = sav_pkg::STEP_N1;
      sav_pkg::ST_MU_GO: begin
        cmd.step      = sav_pkg::STEP_MU;
        cmd.div_start = 1'b1;
      end
      sav_pkg::ST_MU_WAIT:  cmd.step = sav_pkg::STEP_MU;
      sav_pkg::ST_T0:       cmd.step = sav_pkg::STEP_T0;
      sav_pkg::ST_T1:       cmd.step = sav_pkg::STEP_T1;
      sav_pkg::ST_Q0:       cmd.step = sav_pkg::STEP_Q0;
      sav_pkg::ST_Q1:       cmd.step = sav_pkg::STEP_Q1;
      sav_pkg::ST_PIV_GO: begin
        cmd.step      = sav_pkg::STEP_PIV;
        cmd.div_start = 1'b1;
      end
      sav_pkg::ST_PIV_WAIT: cmd.step = sav_pkg::STEP_PIV;
      sav_pkg::ST_GX0:      cmd.step = sav_pkg::STEP_G0;
      sav_pkg::ST_GX1:      cmd.step = sav_pkg::STEP_G1;
      sav_pkg::ST_GX2:      cmd.step = sav_pkg::STEP_G2;
      sav_pkg::ST_GXU:      cmd.step = sav_pkg::STEP_GU;
      sav_pkg::ST_GY0: begin
        cmd.step   = sav_pkg::STEP_G0;
        cmd.axis_y = 1'b1;
      end
      sav_pkg::ST_GY1: begin
        cmd.step   = sav_pkg::STEP_G1;
        cmd.axis_y = 1'b1;
      end
      sav_pkg::ST_GY2: begin
        cmd.step   = sav_pkg::STEP_G2;
        cmd.axis_y = 1'b1;
      end
      sav_pkg::ST_GYU: begin
        cmd.step   = sav_pkg::STEP_GU;
        cmd.axis_y = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && in_kind == sav_pkg::KIND_END) out_valid_nxt = 1'b1;
    else if (out_ready)                          out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sav_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
